>>> design/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check under reset: property is ignored while rstn is low.
`define ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

>>> design/u8dec_pkg.sv
// Types and constants for the UTF-8 to UCS-2 stream decoder.
// No dependencies; used by utf8_to_ucs2_stream_decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_BAD  = 2'd2
    } u8dec_kind_t;

    // Byte tags
    localparam logic [1:0] CONT_TAG  = 2'b10;   // 10xxxxxx
    localparam logic [2:0] LEAD2_TAG = 3'b110;  // 110xxxxx
    localparam logic [3:0] LEAD3_TAG = 4'b1110; // 1110xxxx

    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_start;
    } u8dec_in_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  result_kind;
    } u8dec_out_t;

endpackage

`default_nettype wire

>>> design/utf8_to_ucs2_stream_decoder.sv
// UTF-8 to UCS-2 stream decoder, top level; uses u8dec_pkg and assert_macros.svh.
// Each accepted byte is held in the input register, then decoded into the result
// register, from which any result is presented on m_*. Throughput: one byte per
// cycle while s_ready is high, set by the single decode pass between the two
// registers. s_ready drops only while the result register is full and not taken.
// Reset (aresetn low, synchronous): both stages empty, decoder state cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module utf8_to_ucs2_stream_decoder (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  u8dec_pkg::u8dec_in_t   s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output u8dec_pkg::u8dec_out_t  m_data
);
    import u8dec_pkg::*;

    // Input stage
    logic        in_valid_reg, in_valid_next;
    u8dec_in_t   in_data_reg;

    // Result stage
    logic        m_valid_reg, m_valid_next;
    u8dec_out_t  m_data_reg, m_data_next;

    // Decoder state
    logic [1:0]  pending_reg, pending_next;
    logic [15:0] partial_reg, partial_next;
    logic        halted_reg, halted_next;

    // Decode scratch
    logic        advance;
    logic        emit;
    logic [1:0]  pending_eff;
    logic [15:0] partial_eff;
    logic        halted_eff;
    logic [15:0] shifted;
    logic [7:0]  b;

    // The input beat moves on when the result register can take whatever it
    // produces: either it is empty or its beat is being taken this cycle.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign b = in_data_reg.data_byte;

    // A string_start beat clears the state before its byte is looked at.
    assign pending_eff = in_data_reg.string_start ? 2'd0  : pending_reg;
    assign partial_eff = in_data_reg.string_start ? 16'd0 : partial_reg;
    assign halted_eff  = in_data_reg.string_start ? 1'b0  : halted_reg;
    assign shifted     = {partial_eff[9:0], b[5:0]};

    always_comb begin
        pending_next          = pending_reg;
        partial_next          = partial_reg;
        halted_next           = halted_reg;
        emit                  = 1'b0;
        m_data_next.code_unit   = 16'd0;
        m_data_next.result_kind = KIND_CHAR;
        if (advance) begin
            pending_next = pending_eff;
            partial_next = partial_eff;
            halted_next  = halted_eff;
            if (!halted_eff) begin
                priority if (pending_eff != 2'd0) begin
                    if (b[7:6] != CONT_TAG) begin
                        // missing continuation (NUL included)
                        emit         = 1'b1;
                        m_data_next.result_kind = KIND_BAD;
                        halted_next  = 1'b1;
                        pending_next = 2'd0;
                        partial_next = 16'd0;
                    end else if (pending_eff == 2'd1) begin
                        emit         = 1'b1;
                        m_data_next.code_unit = shifted;
                        pending_next = 2'd0;
                        partial_next = 16'd0;
                    end else begin
                        pending_next = 2'(pending_eff - 2'd1);
                        partial_next = shifted;
                    end
                end else if (b == 8'd0) begin
                    // end of string
                    emit        = 1'b1;
                    m_data_next.result_kind = KIND_END;
                    halted_next = 1'b1;
                end else if (!b[7]) begin
                    emit = 1'b1;
                    m_data_next.code_unit = {9'd0, b[6:0]};
                end else if (b[7:5] == LEAD2_TAG) begin
                    pending_next = 2'd1;
                    partial_next = {11'd0, b[4:0]};
                end else if (b[7:4] == LEAD3_TAG) begin
                    pending_next = 2'd2;
                    partial_next = {12'd0, b[3:0]};
                end else begin
                    // stray continuation or four-byte-and-up lead
                    emit        = 1'b1;
                    m_data_next.result_kind = KIND_BAD;
                    halted_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            m_valid_next = emit;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pending_reg  <= 2'd0;
            partial_reg  <= 16'd0;
            halted_reg   <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            pending_reg  <= pending_next;
            partial_reg  <= partial_next;
            halted_reg   <= halted_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && emit) begin
            m_data_reg <= m_data_next;
        end
    end

    // Checks
    `ASSERT_RST(a_code_zero_unless_char, aclk, aresetn,
        (m_valid && m_data.result_kind != KIND_CHAR) |-> (m_data.code_unit == 16'd0))
    `ASSERT_RST(a_pending_range, aclk, aresetn, pending_reg != 2'd3)
    `ASSERT_RST(a_idle_partial_clear, aclk, aresetn,
        (pending_reg == 2'd0) |-> (partial_reg == 16'd0))
    `ASSERT_RST(a_halted_clear, aclk, aresetn, halted_reg |-> (pending_reg == 2'd0))
    `ASSERT_RST(a_ready_when_out_empty, aclk, aresetn, !m_valid_reg |-> s_ready)

endmodule

`default_nettype wire

>>> tb/utf8_to_ucs2_stream_decoder_tb.sv
// Self-checking testbench for the UTF-8 to UCS-2 stream decoder.
// Depends on u8dec_pkg and utf8_to_ucs2_stream_decoder, which includes assert_macros.svh.
`timescale 1ns / 1ps

module utf8_to_ucs2_stream_decoder_tb;
    import u8dec_pkg::*;

    // Scoreboard: decodes each accepted beat on its own and queues the
    // result that the block should present for it.
    class ucs2_scoreboard;
        logic [1:0]  bytes_pending;
        logic [15:0] partial_code;
        bit          halted;
        u8dec_out_t  expected_units[$];
        int unsigned errors;
        int unsigned chars_seen;
        int unsigned ends_seen;
        int unsigned bad_seen;

        function new();
            bytes_pending = '0;
            partial_code  = '0;
            halted        = 1'b0;
            errors        = 0;
            chars_seen    = 0;
            ends_seen     = 0;
            bad_seen      = 0;
        endfunction

        // End and malformed results stop decoding and drop any partial code.
        function void push_result(logic [15:0] code, u8dec_kind_t kind);
            u8dec_out_t r;
            r.code_unit   = code;
            r.result_kind = kind;
            expected_units.push_back(r);
            if (kind != KIND_CHAR) begin
                halted        = 1'b1;
                bytes_pending = '0;
                partial_code  = '0;
            end
        endfunction

        // Returns 1 when the beat was decoded, 0 when a halted decoder drops it.
        function bit decode_beat(u8dec_in_t beat);
            logic [7:0] b;
            b = beat.data_byte;
            if (beat.string_start) begin
                bytes_pending = '0;
                partial_code  = '0;
                halted        = 1'b0;
            end
            if (halted)
                return 1'b0;
            if (bytes_pending != 2'd0) begin
                if (b[7:6] != CONT_TAG) begin
                    push_result(16'h0000, KIND_BAD);
                end else begin
                    partial_code  = {partial_code[9:0], b[5:0]};
                    bytes_pending = bytes_pending - 2'd1;
                    if (bytes_pending == 2'd0) begin
                        push_result(partial_code, KIND_CHAR);
                        partial_code = '0;
                    end
                end
            end else if (b == 8'h00) begin
                push_result(16'h0000, KIND_END);
            end else if (!b[7]) begin
                push_result({8'h00, b}, KIND_CHAR);
            end else if (b[7:5] == LEAD2_TAG) begin
                partial_code  = {11'd0, b[4:0]};
                bytes_pending = 2'd1;
            end else if (b[7:4] == LEAD3_TAG) begin
                partial_code  = {12'd0, b[3:0]};
                bytes_pending = 2'd2;
            end else begin
                push_result(16'h0000, KIND_BAD);
            end
            return 1'b1;
        endfunction

        function void check_result(u8dec_out_t got);
            u8dec_out_t want;
            if (expected_units.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result code %h kind %0d",
                             $realtime, got.code_unit, got.result_kind);
                return;
            end
            want = expected_units.pop_front();
            case (want.result_kind)
                KIND_CHAR: chars_seen++;
                KIND_END:  ends_seen++;
                default:   bad_seen++;
            endcase
            if (got.code_unit !== want.code_unit ||
                got.result_kind !== want.result_kind) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch: expected code %h kind %0d, got code %h kind %0d",
                             $realtime, want.code_unit, want.result_kind,
                             got.code_unit, got.result_kind);
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    u8dec_in_t  s_data;
    logic       m_valid;
    logic       m_ready;
    u8dec_out_t m_data;

    ucs2_scoreboard ucs2_sb;

    // Idle modes flip now and then so bursts with no gaps show up on both sides.
    bit          src_idle = 1'b1;
    bit          snk_idle = 1'b1;
    int unsigned decoded_beats = 0;
    int unsigned beats_sent = 0;

    utf8_to_ucs2_stream_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Safety net against a hung handshake.
    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Drive one beat: optional gap, then hold valid until the block takes it.
    // Valid is only lowered when a gap follows, so back-to-back beats never
    // see a low/high pair in one time step.
    task automatic send_byte(input logic [7:0] b, input bit start);
        int unsigned gap;
        u8dec_in_t   beat;
        beat.data_byte    = b;
        beat.string_start = start;
        if ($urandom_range(0, 63) == 0)
            src_idle = !src_idle;
        gap = src_idle ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (ucs2_sb.decode_beat(beat))
            decoded_beats++;
        beats_sent++;
    endtask

    // One well-formed character of random length and payload; overlong forms
    // and surrogate values come up naturally from the random bits.
    task automatic send_char(input bit first);
        logic [31:0] bits;
        bits = $urandom;
        case ($urandom_range(1, 3))
            1: send_byte(8'($urandom_range(1, 127)), first);
            2: begin
                send_byte({LEAD2_TAG, bits[4:0]}, first);
                send_byte({CONT_TAG, bits[10:5]}, 1'b0);
            end
            default: begin
                send_byte({LEAD3_TAG, bits[3:0]}, first);
                send_byte({CONT_TAG, bits[9:4]}, 1'b0);
                send_byte({CONT_TAG, bits[15:10]}, 1'b0);
            end
        endcase
    endtask

    // A flagged string of random characters, mostly closed by NUL; a share of
    // strings are left open or break off with a truncated sequence, a bad lead, or plain noise.
    task automatic send_string();
        int unsigned n;
        int unsigned shape;
        logic [7:0]  b;
        n     = $urandom_range(1, 10);
        shape = $urandom_range(0, 99);
        if (shape >= 94) begin
            // noise: any byte, start flag now and then
            repeat (n) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            return;
        end
        for (int i = 0; i < n; i++)
            send_char(i == 0);
        if (shape < 70) begin
            send_byte(8'h00, 1'b0);
        end else if (shape < 78) begin
            // left open: the next string's start flag cuts it off
            return;
        end else if (shape < 86) begin
            // truncated sequence: lead, maybe one continuation, then a non-continuation
            b = 8'($urandom);
            if ($urandom_range(0, 1)) begin
                send_byte({LEAD2_TAG, b[4:0]}, 1'b0);
            end else begin
                send_byte({LEAD3_TAG, b[3:0]}, 1'b0);
                if ($urandom_range(0, 1))
                    send_byte({CONT_TAG, b[7:2]}, 1'b0);
            end
            b = 8'($urandom);
            if ($urandom_range(0, 3) == 0)
                b = 8'h00;
            else if (b[7:6] == CONT_TAG)
                b[6] = 1'b1;
            send_byte(b, 1'b0);
        end else begin
            // bad lead: stray continuation or four-byte-and-up lead
            b = 8'($urandom);
            if (b[0])
                send_byte({CONT_TAG, b[7:2]}, 1'b0);
            else
                send_byte({4'hF, b[7:4]}, 1'b0);
        end
        // trailing bytes land on a halted decoder and must be dropped
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
    endtask

    // Result side: random stall before each beat, then take whatever comes.
    initial begin : result_sink
        int unsigned stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 63) == 0)
                snk_idle = !snk_idle;
            stall = snk_idle ? $urandom_range(0, 16) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            ucs2_sb.check_result(m_data);
        end
    end

    initial begin : stimulus
        int unsigned drain;
        ucs2_sb = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        m_ready <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: ASCII up to 7F, a two-byte character, the three-byte maximum, surrogate,
        // overlong, end of string, dropped byte while halted, bad leads,
        // missing continuation, NUL inside a sequence, restart mid-sequence.
        send_byte(8'h41, 1'b1);  send_byte(8'h7F, 1'b0);
        send_byte(8'hC2, 1'b0);  send_byte(8'hA9, 1'b0);
        send_byte(8'hEF, 1'b0);  send_byte(8'hBF, 1'b0);  send_byte(8'hBF, 1'b0);
        send_byte(8'hED, 1'b0);  send_byte(8'hA0, 1'b0);  send_byte(8'h80, 1'b0);
        send_byte(8'hC0, 1'b0);  send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hF0, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hC2, 1'b1);  send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b1);  send_byte(8'h82, 1'b0);  send_byte(8'h00, 1'b0);
        send_byte(8'hE2, 1'b1);  send_byte(8'hE2, 1'b1);
        send_byte(8'h82, 1'b0);  send_byte(8'hAC, 1'b0);
        send_byte(8'h00, 1'b0);

        // Random strings until about the planned number of beats has gone out.
        while (beats_sent < 1900)
            send_string();
        s_valid <= 1'b0;

        while (ucs2_sb.expected_units.size() != 0) @(posedge aclk);
        // Room for a stray late result even behind a long receiver stall.
        drain = 40;
        repeat (drain) @(posedge aclk);

        $display("Sent %0d beats, %0d decoded; checked %0d characters,",
                 beats_sent, decoded_beats, ucs2_sb.chars_seen);
        $display("%0d string ends, %0d malformed stops", ucs2_sb.ends_seen,
                 ucs2_sb.bad_seen);
        $display("Errors: %0d, results never seen: %0d",
                 ucs2_sb.errors, ucs2_sb.expected_units.size());
        if (ucs2_sb.errors == 0 && ucs2_sb.expected_units.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
